>>> sv/one_wire_bus_master_macros.svh
// Assertion macros for the single-wire bus master.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is asserted
`define OWBM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("owbm check failed");

// clocked check with a caller message
`define OWBM_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`else

`define OWBM_ASSERT(name, prop)
`define OWBM_ASSERT_MSG(name, prop, msg)

`endif

`endif

>>> sv/owbm_pkg.sv
// Shared types and constants of the single-wire bus master.
// No dependencies; used by owbm_cfg, owbm_core and one_wire_bus_master.
`timescale 1ns / 1ps

package owbm_pkg;

  localparam int CountWidthDef = 16;
  localparam int BitsPerByte   = 8;
  localparam int BitIdxWidth   = $clog2(BitsPerByte);
  localparam int ByteWidth     = 8;
  localparam int CfgNum        = 8;
  localparam int CfgIdxWidth   = 3;
  localparam int CfgDataWidth  = 16;
  localparam int TimNum        = 8;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_WAIT   = 3'd1,
    REG_RECOVER     = 3'd2,
    REG_WR1_LOW     = 3'd3,
    REG_WR0_LOW     = 3'd4,
    REG_RD_LOW      = 3'd5,
    REG_RD_SAMPLE   = 3'd6,
    REG_SLOT        = 3'd7
  } cfg_reg_e;

  // derived timing values handed to the core
  typedef enum logic [2:0] {
    TIM_RST_LIM   = 3'd0,
    TIM_PRES_WAIT = 3'd1,
    TIM_RECOVER   = 3'd2,
    TIM_LOW_ONE   = 3'd3,
    TIM_LOW_ZERO  = 3'd4,
    TIM_LOW_READ  = 3'd5,
    TIM_SAMPLE    = 3'd6,
    TIM_SLOT_LAST = 3'd7
  } tim_e;

  localparam logic [CfgDataWidth-1:0] CfgReset [CfgNum] = '{
    16'd3812, 16'd568, 16'd3329, 16'd40, 16'd470, 16'd44, 16'd70, 16'd540
  };

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_RECOV,
    PH_SLOT
  } phase_e;

  typedef struct packed {
    logic                 drive_low;
    logic                 busy_res;
    logic                 op_done;
    logic [ByteWidth-1:0] rx_byte;
    logic                 presence;
    logic                 rejected;
  } res_t;

endpackage

>>> sv/owbm_cfg.sv
// Configuration registers and derived slot timing for the bus master.
// Depends on owbm_pkg.
`timescale 1ns / 1ps

module owbm_cfg #(
  parameter int CountWidth = owbm_pkg::CountWidthDef
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           cfg_we_i,
  input  logic [owbm_pkg::CfgIdxWidth-1:0]               cfg_idx_i,
  input  logic [owbm_pkg::CfgDataWidth-1:0]              cfg_data_i,
  output logic [owbm_pkg::TimNum-1:0][CountWidth-1:0]    timing_o
);

  logic [owbm_pkg::CfgDataWidth-1:0]              cfg_q [owbm_pkg::CfgNum];
  logic [owbm_pkg::CfgNum-1:0][CountWidth-1:0]    sat;
  logic [CountWidth-1:0]                          slot_len;
  logic [CountWidth-1:0]                          slot_last;
  logic [CountWidth-1:0]                          low_read;
  logic [CountWidth:0]                            sample_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < owbm_pkg::CfgNum; i++) begin
        cfg_q[i] <= owbm_pkg::CfgReset[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // saturate each register to what the tick counter can hold
  for (genvar g = 0; g < owbm_pkg::CfgNum; g++) begin : g_sat
    if (CountWidth >= owbm_pkg::CfgDataWidth) begin : g_wide
      assign sat[g] = CountWidth'(cfg_q[g]);
    end else begin : g_narrow
      assign sat[g] = (|cfg_q[g][owbm_pkg::CfgDataWidth-1:CountWidth]) ?
                      '1 : cfg_q[g][CountWidth-1:0];
    end
  end

  function automatic logic [CountWidth-1:0] clamp_low(
    input logic [CountWidth-1:0] l,
    input logic [CountWidth-1:0] last
  );
    logic [CountWidth-1:0] r;
    r = (l == '0) ? CountWidth'(1) : l;
    if (r > last) r = last;
    return r;
  endfunction

  always_comb begin
    slot_len  = (sat[owbm_pkg::REG_SLOT] < CountWidth'(2)) ?
                CountWidth'(2) : sat[owbm_pkg::REG_SLOT];
    slot_last = slot_len - CountWidth'(1);
    low_read  = clamp_low(sat[owbm_pkg::REG_RD_LOW], slot_last);
    sample_sum = {1'b0, low_read} + {1'b0, sat[owbm_pkg::REG_RD_SAMPLE]};

    timing_o[owbm_pkg::TIM_RST_LIM]   = (sat[owbm_pkg::REG_RESET_LOW] == '0) ?
                                        CountWidth'(1) : sat[owbm_pkg::REG_RESET_LOW];
    timing_o[owbm_pkg::TIM_PRES_WAIT] = sat[owbm_pkg::REG_PRES_WAIT];
    timing_o[owbm_pkg::TIM_RECOVER]   = sat[owbm_pkg::REG_RECOVER];
    timing_o[owbm_pkg::TIM_LOW_ONE]   = clamp_low(sat[owbm_pkg::REG_WR1_LOW], slot_last);
    timing_o[owbm_pkg::TIM_LOW_ZERO]  = clamp_low(sat[owbm_pkg::REG_WR0_LOW], slot_last);
    timing_o[owbm_pkg::TIM_LOW_READ]  = low_read;
    // sample point past the slot end falls on the last slot tick
    timing_o[owbm_pkg::TIM_SAMPLE]    = (sample_sum > {1'b0, slot_last}) ?
                                        slot_last : sample_sum[CountWidth-1:0];
    timing_o[owbm_pkg::TIM_SLOT_LAST] = slot_last;
  end

endmodule

>>> sv/owbm_core.sv
// Bus sequencer: phase state machine, tick counter, bit counter and shifter.
// Depends on owbm_pkg; timing comes from owbm_cfg.
`timescale 1ns / 1ps

module owbm_core #(
  parameter int CountWidth = owbm_pkg::CountWidthDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        step_i,
  input  logic [1:0]                                  req_i,
  input  logic [owbm_pkg::ByteWidth-1:0]              tx_i,
  input  logic                                        lvl_i,
  input  logic [owbm_pkg::TimNum-1:0][CountWidth-1:0] timing_i,
  output owbm_pkg::res_t                              res_o
);

  owbm_pkg::phase_e                   phase_q, phase_d, ph_eff;
  owbm_pkg::req_e                     req, kind_q, kind_d, kind0;
  logic [CountWidth-1:0]              tick_q, tick_d, t0, t_inc;
  logic [owbm_pkg::BitIdxWidth-1:0]   bit_q, bit_d, bit0;
  logic [owbm_pkg::ByteWidth-1:0]     shift_q, shift_d, shift0, shift1;
  logic [owbm_pkg::ByteWidth-1:0]     rx_q, rx_d;
  logic                               pres_q, pres_d;
  logic                               start, is_read;
  logic                               low_end, wait_end, recov_end, slot_end, last_bit;
  logic [CountWidth-1:0]              low_time;
  logic                               drive, done;

  assign req = owbm_pkg::req_e'(req_i);

  // a command on an idle tick is handled on that same tick
  always_comb begin
    start  = (phase_q == owbm_pkg::PH_IDLE) && (req != owbm_pkg::REQ_NONE);
    if (start) begin
      ph_eff = (req == owbm_pkg::REQ_RESET) ? owbm_pkg::PH_RST_LOW : owbm_pkg::PH_SLOT;
    end else begin
      ph_eff = phase_q;
    end
    t0     = start ? '0 : tick_q;
    t_inc  = t0 + CountWidth'(1);
    kind0  = start ? req : kind_q;
    bit0   = start ? '0 : bit_q;
    shift0 = start ? ((req == owbm_pkg::REQ_WRITE) ? tx_i : '0) : shift_q;
    is_read   = (kind0 == owbm_pkg::REQ_READ);
    low_end   = (t_inc >= timing_i[owbm_pkg::TIM_RST_LIM]);
    wait_end  = (t0 >= timing_i[owbm_pkg::TIM_PRES_WAIT]);
    recov_end = (t0 >= timing_i[owbm_pkg::TIM_RECOVER]);
    slot_end  = (t0 >= timing_i[owbm_pkg::TIM_SLOT_LAST]);
    last_bit  = (bit0 == owbm_pkg::BitIdxWidth'(owbm_pkg::BitsPerByte - 1));
  end

  // next phase
  always_comb begin
    case (ph_eff)
      owbm_pkg::PH_IDLE:      phase_d = owbm_pkg::PH_IDLE;
      owbm_pkg::PH_RST_LOW:   phase_d = low_end ? owbm_pkg::PH_RST_WAIT : owbm_pkg::PH_RST_LOW;
      owbm_pkg::PH_RST_WAIT:  phase_d = wait_end ? owbm_pkg::PH_RST_RECOV
                                                 : owbm_pkg::PH_RST_WAIT;
      owbm_pkg::PH_RST_RECOV: phase_d = recov_end ? owbm_pkg::PH_IDLE
                                                  : owbm_pkg::PH_RST_RECOV;
      owbm_pkg::PH_SLOT:      phase_d = (slot_end && last_bit) ? owbm_pkg::PH_IDLE
                                                               : owbm_pkg::PH_SLOT;
      default:                phase_d = owbm_pkg::PH_IDLE;
    endcase
  end

  // datapath and per-tick outputs
  always_comb begin
    tick_d  = t0;
    bit_d   = bit0;
    kind_d  = kind0;
    shift_d = shift0;
    pres_d  = pres_q;
    rx_d    = rx_q;
    drive   = 1'b0;
    done    = 1'b0;
    shift1  = shift0;
    if (is_read) begin
      low_time = timing_i[owbm_pkg::TIM_LOW_READ];
    end else if (shift0[0]) begin
      low_time = timing_i[owbm_pkg::TIM_LOW_ONE];
    end else begin
      low_time = timing_i[owbm_pkg::TIM_LOW_ZERO];
    end
    case (ph_eff)
      owbm_pkg::PH_RST_LOW: begin
        drive  = 1'b1;
        tick_d = low_end ? '0 : t_inc;
      end
      owbm_pkg::PH_RST_WAIT: begin
        if (wait_end) begin
          pres_d = ~lvl_i;
          tick_d = '0;
        end else begin
          tick_d = t_inc;
        end
      end
      owbm_pkg::PH_RST_RECOV: begin
        if (recov_end) begin
          done   = 1'b1;
          tick_d = '0;
        end else begin
          tick_d = t_inc;
        end
      end
      owbm_pkg::PH_SLOT: begin
        drive = (t0 < low_time);
        // read bits enter at the top, lsb first on the wire
        if (is_read && (t0 == timing_i[owbm_pkg::TIM_SAMPLE])) begin
          shift1 = {lvl_i, shift0[owbm_pkg::ByteWidth-1:1]};
        end
        shift_d = shift1;
        if (slot_end) begin
          if (!is_read) begin
            shift_d = shift1 >> 1;
          end
          tick_d = '0;
          if (last_bit) begin
            done  = 1'b1;
            bit_d = '0;
            if (is_read) begin
              rx_d = shift1;
            end
          end else begin
            bit_d = bit0 + owbm_pkg::BitIdxWidth'(1);
          end
        end else begin
          tick_d = t_inc;
        end
      end
      default: ;
    endcase

    res_o.drive_low = drive;
    res_o.busy_res  = (ph_eff != owbm_pkg::PH_IDLE);
    res_o.op_done   = done;
    res_o.rx_byte   = rx_d;
    res_o.presence  = pres_d;
    res_o.rejected  = (phase_q != owbm_pkg::PH_IDLE) && (req != owbm_pkg::REQ_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owbm_pkg::PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      kind_q  <= owbm_pkg::REQ_NONE;
      pres_q  <= 1'b0;
      rx_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      kind_q  <= kind_d;
      pres_q  <= pres_d;
      rx_q    <= rx_d;
    end
  end

endmodule

>>> sv/one_wire_bus_master.sv
// Top level of the single-wire bus master: config registers, sequencer, result register.
// Depends on owbm_pkg, owbm_cfg, owbm_core and one_wire_bus_master_macros.svh.
`timescale 1ns / 1ps
`include "one_wire_bus_master_macros.svh"

// Each input beat is one bus tick carrying an optional command, the byte to
// send and the sampled line level; each accepted beat yields exactly one
// result beat with the line drive, busy, done, presence, rejected and the
// last read byte. The sequencer handles a tick in one pass; its result lands
// in a single output register, and a new tick is taken whenever that register
// is empty or being drained, so throughput is one tick per clock unless the
// output stalls. All slot and reset timing is counted in ticks from the
// configuration registers; the user is to write them only while the bus
// master is idle (not enforced). No memory, so no start-up sweep after reset.
module one_wire_bus_master #(
  parameter int CountWidth = owbm_pkg::CountWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          req_type_i,
  input  logic [owbm_pkg::ByteWidth-1:0]      tx_byte_i,
  input  logic                                bus_level_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                drive_low_o,
  output logic                                busy_res_o,
  output logic                                op_done_o,
  output logic [owbm_pkg::ByteWidth-1:0]      rx_byte_o,
  output logic                                presence_o,
  output logic                                rejected_o,
  input  logic                                cfg_we_i,
  input  logic [owbm_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [owbm_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  logic [owbm_pkg::TimNum-1:0][CountWidth-1:0] timing;
  owbm_pkg::res_t                              res_d, res_q;
  logic                                        out_valid_q;
  logic                                        accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  owbm_cfg #(
    .CountWidth(CountWidth)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .timing_o  (timing)
  );

  owbm_core #(
    .CountWidth(CountWidth)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept),
    .req_i   (req_type_i),
    .tx_i    (tx_byte_i),
    .lvl_i   (bus_level_i),
    .timing_i(timing),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = res_q.drive_low;
  assign busy_res_o  = res_q.busy_res;
  assign op_done_o   = res_q.op_done;
  assign rx_byte_o   = res_q.rx_byte;
  assign presence_o  = res_q.presence;
  assign rejected_o  = res_q.rejected;

  `OWBM_ASSERT(a_accept_fills_out, accept |=> out_valid_q)
  `OWBM_ASSERT_MSG(a_reject_only_busy, (out_valid_q && res_q.rejected) |-> res_q.busy_res, "reject while idle")
  `OWBM_ASSERT_MSG(a_drive_only_busy, (out_valid_q && res_q.drive_low) |-> res_q.busy_res, "line driven while idle")

endmodule

>>> tb/tb.sv
// Self-checking testbench for one_wire_bus_master: drives bus ticks, predicts every result beat.
// Depends on owbm_pkg and the one_wire_bus_master RTL.
`timescale 1ns / 1ps

module tb;
  import owbm_pkg::*;

  typedef enum int {
    LINE_LOW,
    LINE_HIGH,
    LINE_RAND
  } line_mode_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              req_type;
  logic [ByteWidth-1:0]    tx_byte;
  logic                    bus_level;
  logic                    out_valid;
  logic                    out_ready;
  logic                    drive_low;
  logic                    busy_res;
  logic                    op_done;
  logic [ByteWidth-1:0]    rx_byte;
  logic                    presence;
  logic                    rejected;
  logic                    cfg_we;
  logic [CfgIdxWidth-1:0]  cfg_idx;
  logic [CfgDataWidth-1:0] cfg_data;

  bit          gaps_on = 1'b0;
  int unsigned ticks_sent = 0;
  int unsigned mismatch_count = 0;
  res_t        tick_results [$];

  // mirror of the bus master state
  phase_e                  m_phase;
  int unsigned             m_ticks;
  int unsigned             m_bit;
  logic [ByteWidth-1:0]    m_shift;
  logic [ByteWidth-1:0]    m_rx_last;
  req_e                    m_kind;
  logic                    m_presence;
  logic [CfgDataWidth-1:0] m_timing [CfgNum];

  one_wire_bus_master dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .tx_byte_i   (tx_byte),
    .bus_level_i (bus_level),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .drive_low_o (drive_low),
    .busy_res_o  (busy_res),
    .op_done_o   (op_done),
    .rx_byte_o   (rx_byte),
    .presence_o  (presence),
    .rejected_o  (rejected),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // one bus tick of the master: advances the mirrored state, returns the result beat
  function automatic res_t step_bus_master(req_e req, logic [7:0] tx, logic lvl);
    res_t        r;
    int unsigned lim;
    int unsigned slen;
    int unsigned low;
    int unsigned samp;
    r = '0;
    if (m_phase == PH_IDLE) begin
      if (req != REQ_NONE) begin
        m_kind  = req;
        m_ticks = 0;
        m_bit   = 0;
        if (req == REQ_RESET) begin
          m_phase = PH_RST_LOW;
        end else begin
          m_phase = PH_SLOT;
          m_shift = (req == REQ_WRITE) ? tx : 8'h00;
        end
      end
    end else if (req != REQ_NONE) begin
      r.rejected = 1'b1;
    end
    r.busy_res = (m_phase != PH_IDLE);
    case (m_phase)
      PH_RST_LOW: begin
        lim = m_timing[REG_RESET_LOW];
        if (lim < 1) lim = 1;
        r.drive_low = 1'b1;
        m_ticks++;
        if (m_ticks >= lim) begin
          m_phase = PH_RST_WAIT;
          m_ticks = 0;
        end
      end
      PH_RST_WAIT: begin
        if (m_ticks >= m_timing[REG_PRES_WAIT]) begin
          m_presence = ~lvl;
          m_phase    = PH_RST_RECOV;
          m_ticks    = 0;
        end else begin
          m_ticks++;
        end
      end
      PH_RST_RECOV: begin
        if (m_ticks >= m_timing[REG_RECOVER]) begin
          r.op_done = 1'b1;
          m_phase   = PH_IDLE;
          m_ticks   = 0;
        end else begin
          m_ticks++;
        end
      end
      PH_SLOT: begin
        slen = m_timing[REG_SLOT];
        if (slen < 2) slen = 2;
        if (m_kind == REQ_READ) low = m_timing[REG_RD_LOW];
        else if (m_shift[0]) low = m_timing[REG_WR1_LOW];
        else low = m_timing[REG_WR0_LOW];
        if (low < 1) low = 1;
        if (low > slen - 1) low = slen - 1;
        r.drive_low = (m_ticks < low);
        if (m_kind == REQ_READ) begin
          // sample point past the slot end falls on the last slot tick
          samp = low + m_timing[REG_RD_SAMPLE];
          if (samp > slen - 1) samp = slen - 1;
          if (m_ticks == samp) m_shift = {lvl, m_shift[7:1]};
        end
        if (m_ticks >= slen - 1) begin
          if (m_kind != REQ_READ) m_shift = m_shift >> 1;
          m_ticks = 0;
          if (m_bit >= BitsPerByte - 1) begin
            r.op_done = 1'b1;
            m_phase   = PH_IDLE;
            m_bit     = 0;
            if (m_kind == REQ_READ) m_rx_last = m_shift;
          end else begin
            m_bit++;
          end
        end else begin
          m_ticks++;
        end
      end
      default: ;
    endcase
    r.rx_byte  = m_rx_last;
    r.presence = m_presence;
    return r;
  endfunction

  function automatic logic line_of(line_mode_e mode);
    if (mode == LINE_RAND) return 1'($urandom_range(0, 1));
    return (mode == LINE_HIGH);
  endfunction

  function automatic logic [15:0] small_or_max(int unsigned hi);
    if ($urandom_range(0, 7) == 0) return 16'hFFFF;
    return 16'($urandom_range(0, hi));
  endfunction

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (tick_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with none expected, actual %0h", $time,
                 {drive_low, busy_res, op_done, rx_byte, presence, rejected});
      end else begin
        want = tick_results.pop_front();
        check_field("drive_low", 8'(want.drive_low), 8'(drive_low));
        check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
        check_field("op_done", 8'(want.op_done), 8'(op_done));
        check_field("rx_byte", want.rx_byte, rx_byte);
        check_field("presence", 8'(want.presence), 8'(presence));
        check_field("rejected", 8'(want.rejected), 8'(rejected));
      end
    end
  end

  // result side back-pressure
  initial begin : result_ready_gen
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_tick(req_e req, logic [7:0] tx, logic lvl);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    tx_byte   <= tx;
    bus_level <= lvl;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    tick_results.push_back(step_bus_master(req, tx, lvl));
    ticks_sent++;
  endtask

  // plain ticks with no command, a running operation just advances
  task automatic run_ticks(int unsigned n, line_mode_e mode);
    for (int unsigned k = 0; k < n; k++) begin
      send_tick(REQ_NONE, 8'($urandom), line_of(mode));
    end
  endtask

  // tick until the master is idle again;
  // poke_pct is the chance of a stray command on each busy tick
  task automatic finish_op(line_mode_e mode, int unsigned poke_pct);
    req_e extra;
    while (m_phase != PH_IDLE) begin
      extra = ($urandom_range(1, 100) <= poke_pct) ? req_e'($urandom_range(1, 3)) : REQ_NONE;
      send_tick(extra, 8'($urandom), line_of(mode));
    end
  endtask

  // issue one command and tick until the master is idle again
  task automatic run_op(req_e req, logic [7:0] tx, line_mode_e mode, int unsigned poke_pct);
    send_tick(req, tx, line_of(mode));
    finish_op(mode, poke_pct);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tick_results.size() != 0);
  endtask

  task automatic program_regs(input logic [15:0] rst_low, input logic [15:0] pres_wait,
                              input logic [15:0] recover, input logic [15:0] wr1_low,
                              input logic [15:0] wr0_low, input logic [15:0] rd_low,
                              input logic [15:0] rd_sample, input logic [15:0] slot);
    logic [15:0] vals [CfgNum];
    vals[REG_RESET_LOW] = rst_low;
    vals[REG_PRES_WAIT] = pres_wait;
    vals[REG_RECOVER]   = recover;
    vals[REG_WR1_LOW]   = wr1_low;
    vals[REG_WR0_LOW]   = wr0_low;
    vals[REG_RD_LOW]    = rd_low;
    vals[REG_RD_SAMPLE] = rd_sample;
    vals[REG_SLOT]      = slot;
    // quiet bus: nothing owed before the registers are written
    drain_results();
    repeat (3) @(posedge clk_i);
    for (int i = 0; i < CfgNum; i++) begin
      cfg_we      <= 1'b1;
      cfg_idx     <= i[CfgIdxWidth-1:0];
      cfg_data    <= vals[i];
      m_timing[i]  = vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic program_stock();
    program_regs(CfgReset[REG_RESET_LOW], CfgReset[REG_PRES_WAIT], CfgReset[REG_RECOVER],
                 CfgReset[REG_WR1_LOW], CfgReset[REG_WR0_LOW], CfgReset[REG_RD_LOW],
                 CfgReset[REG_RD_SAMPLE], CfgReset[REG_SLOT]);
  endtask

  task automatic program_fast();
    program_regs(16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd2);
  endtask

  task automatic program_random_small();
    program_regs(16'($urandom_range(0, 12)), 16'($urandom_range(0, 10)),
                 16'($urandom_range(0, 10)), small_or_max(12), small_or_max(12),
                 small_or_max(12), small_or_max(12), 16'($urandom_range(0, 8)));
  endtask

  // values out of reset: each operation starts at stock timing, then the
  // timing is cut short while it runs so that it ends soon
  task automatic test_stock_timing();
    gaps_on = 1'b0;
    send_tick(REQ_NONE, 8'h00, 1'b1);
    send_tick(REQ_RESET, 8'h00, 1'b0);
    run_ticks(10, LINE_LOW);
    program_fast();
    finish_op(LINE_LOW, 1);
    program_stock();
    // bit 0 is a one, so the line is released after the short low time
    send_tick(REQ_WRITE, 8'hA5, 1'b1);
    run_ticks(44, LINE_RAND);
    program_fast();
    finish_op(LINE_RAND, 0);
    program_stock();
    send_tick(REQ_READ, 8'h00, 1'b1);
    run_ticks(48, LINE_HIGH);
    program_fast();
    finish_op(LINE_HIGH, 1);
  endtask

  // shortest legal timings, then all zeros which must act as the minimums
  task automatic test_short_timing();
    gaps_on = 1'b1;
    program_regs(16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd2);
    run_op(REQ_RESET, 8'h00, LINE_LOW, 100);
    run_op(REQ_WRITE, 8'h00, LINE_RAND, 0);
    run_op(REQ_WRITE, 8'hFF, LINE_RAND, 0);
    run_op(REQ_READ, 8'h00, LINE_LOW, 0);
    // stray commands on every busy tick, done tick included
    run_op(REQ_READ, 8'h00, LINE_RAND, 100);
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_op(REQ_RESET, 8'h00, LINE_HIGH, 0);
    run_op(REQ_WRITE, 8'h5A, LINE_RAND, 50);
    run_op(REQ_READ, 8'h00, LINE_RAND, 0);
  endtask

  // low times and sample point beyond the slot get clipped to its last tick
  task automatic test_clamped_slot();
    gaps_on = 1'b1;
    program_regs(16'd2, 16'd3, 16'd1, 16'hFFFF, 16'd9, 16'hFFFF, 16'hFFFF, 16'd6);
    run_op(REQ_WRITE, 8'h96, LINE_RAND, 0);
    run_op(REQ_READ, 8'h00, LINE_RAND, 0);
    program_regs(16'd3, 16'd2, 16'd2, 16'd2, 16'd5, 16'd3, 16'd1, 16'd5);
    run_op(REQ_READ, 8'h00, LINE_RAND, 10);
    run_op(REQ_WRITE, 8'h3C, LINE_RAND, 10);
  endtask

  // every register at its top value; the reset holds the line for a while,
  // then shorter timing lets it end
  task automatic test_stretched_reset();
    gaps_on = 1'b0;
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF);
    send_tick(REQ_RESET, 8'h00, 1'b0);
    run_ticks(20, LINE_LOW);
    program_fast();
    finish_op(LINE_LOW, 0);
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    gaps_on = 1'b1;
    stop_at = ticks_sent + 90;
    while (ticks_sent < stop_at) begin
      program_random_small();
      for (int op = 0; op < 3 && ticks_sent < stop_at; op++) begin
        if ($urandom_range(0, 5) == 0) drain_results();
        if ($urandom_range(0, 6) == 0) begin
          send_tick(REQ_NONE, 8'($urandom), 1'($urandom));
        end else begin
          run_op(req_e'($urandom_range(1, 3)), 8'($urandom), LINE_RAND, 4);
        end
      end
    end
  endtask

  task automatic test_tail_back_to_back();
    int unsigned stop_at;
    gaps_on = 1'b0;
    program_random_small();
    stop_at = ticks_sent + 25;
    while (ticks_sent < stop_at) begin
      run_op(req_e'($urandom_range(1, 3)), 8'($urandom), LINE_RAND, 4);
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    req_type  = REQ_NONE;
    tx_byte   = '0;
    bus_level = 1'b1;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    m_phase    = PH_IDLE;
    m_ticks    = 0;
    m_bit      = 0;
    m_shift    = '0;
    m_rx_last  = '0;
    m_kind     = REQ_NONE;
    m_presence = 1'b0;
    for (int i = 0; i < CfgNum; i++) m_timing[i] = CfgReset[i];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stock_timing();
    test_short_timing();
    test_clamped_slot();
    test_stretched_reset();
    test_random_traffic();
    test_tail_back_to_back();

    drain_results();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/owbm_pkg.sv
sv/owbm_cfg.sv
sv/owbm_core.sv
sv/one_wire_bus_master.sv
tb/tb.sv
